### rtl/bloom_filter_string_keys_assert.svh
// Assertion macros used by the RTL top level.
`ifndef BLOOM_FILTER_STRING_KEYS_ASSERT_SVH
`define BLOOM_FILTER_STRING_KEYS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFSK_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfsk: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BFSK_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfsk: next-cycle check failed");

`endif

### rtl/bfsk_pkg.sv
package bfsk_pkg;

  // Field and register widths
  localparam int KEY_W     = 8;
  localparam int HASH_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int FS_W      = 13;
  localparam int NH_W      = 4;
  localparam int BIT_CNT_W = $clog2(HASH_W);

  // Default sizing
  localparam int FILTER_BITS_DEF = 4096;
  localparam int MAX_HASHES_DEF  = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES  = 2'd1;

  // Register reset values
  localparam logic [FS_W-1:0] FS_RESET = 13'd4096;
  localparam logic [NH_W-1:0] NH_RESET = 4'd6;

  // Hash constants
  localparam logic [HASH_W-1:0] HASH_SALT  = 32'd31;
  localparam logic [HASH_W-1:0] HASH_MUL   = 32'd11;
  localparam int                HASH_SHIFT = 5;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;     // clearing sweep writes one bit
    logic hash_adv;   // advance accumulators by the input byte
    logic hash_first; // key end: point at first hash, arm the match flag
    logic hash_next;  // step to the next hash
    logic key_clear;  // zero the accumulators
    logic mod_start;  // start reducing the selected hash
    logic mem_set;    // set the probed bit
    logic mem_rd;     // read the probed bit
    logic acc_and;    // fold the read bit into the match flag
    logic emit;       // present the lookup result
  } bfsk_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic hash_last;
  } bfsk_sts_t;

  function automatic logic [HASH_W-1:0] asr(input logic [HASH_W-1:0] h);
    asr = $unsigned($signed(h) >>> HASH_SHIFT);
  endfunction

  // One byte step of hash number sel
  function automatic logic [HASH_W-1:0] hash_step(input logic [3:0] sel,
                                                  input logic [HASH_W-1:0] h,
                                                  input logic [HASH_W-1:0] b);
    logic [HASH_W-1:0] r;
    r = h;
    case (sel)
      4'd0:    r = h + b + HASH_SALT;
      4'd1:    r = h + b * 32'd31;
      4'd2:    r = h + (b + HASH_SALT) * HASH_MUL;
      4'd3:    r = asr(h) + b;
      4'd4:    r = (h << HASH_SHIFT) + b;
      4'd5:    r = (h << HASH_SHIFT) + asr(h) + b;
      4'd6:    r = h + b * HASH_MUL + HASH_SALT;
      4'd7:    r = ((h << HASH_SHIFT) + asr(h)) * HASH_MUL + b;
      4'd8:    r = asr(h) * HASH_MUL + b;
      4'd9:    r = (h << HASH_SHIFT) * HASH_MUL + b;
      default: r = h;
    endcase
    return r;
  endfunction

endpackage

### rtl/bfsk_modunit.sv
// Restoring remainder, one dividend bit per cycle
module bfsk_modunit #(
  parameter int FILTER_BITS = bfsk_pkg::FILTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [bfsk_pkg::HASH_W-1:0]         value,
  input  logic [$clog2(FILTER_BITS+1)-1:0]    modulus,
  output logic                                done,
  output logic [$clog2(FILTER_BITS)-1:0]      rem
);
  import bfsk_pkg::*;

  localparam int MOD_W = $clog2(FILTER_BITS + 1);
  localparam int IDX_W = $clog2(FILTER_BITS);

  logic [HASH_W-1:0]    dividend;
  logic [MOD_W-1:0]     part;
  logic [MOD_W:0]       shifted;
  logic [BIT_CNT_W-1:0] cnt;
  logic                 run;

  assign shifted = {part, dividend[HASH_W-1]};
  assign rem     = part[IDX_W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == BIT_CNT_W'(HASH_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder step
  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= value;
      part     <= '0;
    end else if (run) begin
      dividend <= dividend << 1;
      if (shifted >= {1'b0, modulus}) begin
        part <= MOD_W'(shifted - {1'b0, modulus});
      end else begin
        part <= shifted[MOD_W-1:0];
      end
    end
  end

endmodule

### rtl/bfsk_datapath.sv
// Hash accumulators, config registers, bit store and result register
module bfsk_datapath #(
  parameter int FILTER_BITS = bfsk_pkg::FILTER_BITS_DEF,
  parameter int MAX_HASHES  = bfsk_pkg::MAX_HASHES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bfsk_pkg::bfsk_cmd_t              cmd,
  output bfsk_pkg::bfsk_sts_t              sts,
  input  logic signed [bfsk_pkg::KEY_W-1:0] key_byte,
  input  logic                             cfg_we,
  input  logic [bfsk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfsk_pkg::CFG_W-1:0]       cfg_data,
  output logic                             done,
  output logic                             found
);
  import bfsk_pkg::*;

  localparam int MOD_W = $clog2(FILTER_BITS + 1);
  localparam int IDX_W = $clog2(FILTER_BITS);
  localparam int HI_W  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int CMP_W = (MOD_W > FS_W) ? MOD_W : FS_W;

  logic [FS_W-1:0]   size_cfg;
  logic [NH_W-1:0]   num_hashes;
  logic [HASH_W-1:0] hacc [MAX_HASHES];
  logic [HASH_W-1:0] byte_ext;
  logic [HI_W-1:0]   hidx;
  logic [HI_W-1:0]   k_last;
  logic [CMP_W-1:0]  fs_ext;
  logic [MOD_W-1:0]  mod_eff;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  clr_addr;
  logic              mod_done;
  logic              all_ok;
  logic              rd_bit;
  logic              mem [FILTER_BITS];

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg   <= FS_RESET;
      num_hashes <= NH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FILTER_SIZE) begin
        size_cfg <= cfg_data[FS_W-1:0];
      end else if (cfg_index == REG_NUM_HASHES) begin
        num_hashes <= cfg_data[NH_W-1:0];
      end
    end
  end

  // Clamp modulus to 1..FILTER_BITS
  always_comb begin
    fs_ext = CMP_W'(size_cfg);
    if (fs_ext == '0) begin
      mod_eff = MOD_W'(1);
    end else if (fs_ext > CMP_W'(FILTER_BITS)) begin
      mod_eff = MOD_W'(FILTER_BITS);
    end else begin
      mod_eff = MOD_W'(fs_ext);
    end
  end

  // Clamp hash count to 1..MAX_HASHES, as a last index
  always_comb begin
    if (num_hashes == '0) begin
      k_last = '0;
    end else if (num_hashes > NH_W'(MAX_HASHES)) begin
      k_last = HI_W'(MAX_HASHES - 1);
    end else begin
      k_last = HI_W'(num_hashes - 1'b1);
    end
  end

  // Running hashes, sign-extended byte
  assign byte_ext = {{(HASH_W - KEY_W){key_byte[KEY_W-1]}}, key_byte};

  for (genvar g = 0; g < MAX_HASHES; g++) begin : g_hash
    always_ff @(posedge clk) begin
      if (rst || cmd.key_clear) begin
        hacc[g] <= '0;
      end else if (cmd.hash_adv) begin
        hacc[g] <= hash_step(4'(g), hacc[g], byte_ext);
      end
    end
  end

  // Hash index and match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hidx   <= '0;
      all_ok <= 1'b1;
    end else if (cmd.hash_first) begin
      hidx   <= '0;
      all_ok <= 1'b1;
    end else begin
      if (cmd.hash_next) begin
        hidx <= hidx + 1'b1;
      end
      if (cmd.acc_and) begin
        all_ok <= all_ok & rd_bit;
      end
    end
  end

  bfsk_modunit #(
    .FILTER_BITS(FILTER_BITS)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mod_start),
    .value  (hacc[hidx]),
    .modulus(mod_eff),
    .done   (mod_done),
    .rem    (rem)
  );

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Bit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr] <= 1'b0;
    end else if (cmd.mem_set) begin
      mem[rem] <= 1'b1;
    end
    if (cmd.mem_rd) begin
      rd_bit <= mem[rem];
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found <= all_ok;
    end
  end

  assign sts.clr_last  = (clr_addr == IDX_W'(FILTER_BITS - 1));
  assign sts.mod_done  = mod_done;
  assign sts.hash_last = (hidx == k_last);

endmodule

### rtl/bfsk_ctrl.sv
// Sequencer: clearing sweep, byte intake, per-hash reduce and probe
module bfsk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                req_type,
  input  logic                key_end,
  output logic                busy,
  output bfsk_pkg::bfsk_cmd_t cmd,
  input  bfsk_pkg::bfsk_sts_t sts
);
  import bfsk_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PROBE  = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       lookup;
  logic       lookup_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      lookup <= 1'b0;
    end else begin
      state  <= state_next;
      lookup <= lookup_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    lookup_next = lookup;
    cmd         = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.hash_adv = 1'b1;
          if (key_end) begin
            cmd.hash_first = 1'b1;
            lookup_next    = req_type;
            state_next     = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.mod_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.mod_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lookup) begin
          cmd.mem_rd = 1'b1;
          state_next = S_CHECK;
        end else begin
          cmd.mem_set = 1'b1;
          if (sts.hash_last) begin
            state_next = S_FINISH;
          end else begin
            cmd.hash_next = 1'b1;
            state_next    = S_LOAD;
          end
        end
      end
      S_CHECK: begin
        cmd.acc_and = 1'b1;
        if (sts.hash_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.hash_next = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_FINISH: begin
        cmd.key_clear = 1'b1;
        cmd.emit      = lookup;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bloom_filter_string_keys.sv
// Bloom filter over byte-string keys, one key byte per start beat.
// A non-final byte is taken while busy stays low, so bytes may follow back to back.
// Key end: each of k hashes is loaded, reduced in the 32-step remainder unit and probed (then checked on lookup),
// then a closing state follows; on a lookup the found strobe is registered from that closing state.
// The done strobe lasts one cycle and cannot be held off by the receiver.
// After rst the bit store is swept clear with busy high; config is taken.
`include "bloom_filter_string_keys_assert.svh"

module bloom_filter_string_keys #(
  parameter int FILTER_BITS = bfsk_pkg::FILTER_BITS_DEF,
  parameter int MAX_HASHES  = bfsk_pkg::MAX_HASHES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic signed [bfsk_pkg::KEY_W-1:0] key_byte,
  input  logic                              key_end,
  output logic                              done,
  output logic                              found,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfsk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfsk_pkg::CFG_W-1:0]        cfg_data
);
  import bfsk_pkg::*;

  bfsk_cmd_t cmd;
  bfsk_sts_t sts;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  bfsk_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .key_end (key_end),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  bfsk_datapath #(
    .FILTER_BITS(FILTER_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .key_byte (key_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .found    (found)
  );

  // A result is a single beat per lookup key
  `BFSK_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  // A non-final byte leaves the block ready for the next
  `BFSK_ASSERT_NXT(a_byte_ready, clk, rst, start && !busy && !key_end, !busy)
  // The last byte starts the reduce and probe pass
  `BFSK_ASSERT_NXT(a_end_busy, clk, rst, start && !busy && key_end, busy)
  // The sweep and a key never share the write port
  `BFSK_ASSERT_IMP(a_port_excl, clk, rst, cmd.clr_en, !cmd.mem_set && !busy == 1'b0)

endmodule

### sim/bloom_filter_string_keys_chk.sv
`timescale 1ns / 100ps

// Watches the key, config and result channels, keeps its own copy of the
// filter and checks every found beat against the oldest lookup outstanding.
module bloom_filter_string_keys_chk #(
  parameter int FILTER_BITS = bfsk_pkg::FILTER_BITS_DEF,
  parameter int MAX_HASHES  = bfsk_pkg::MAX_HASHES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              req_type,
  input  logic signed [bfsk_pkg::KEY_W-1:0] key_byte,
  input  logic                              key_end,
  input  logic                              done,
  input  logic                              found,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bfsk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfsk_pkg::CFG_W-1:0]        cfg_data,
  output int                                fails,
  output int                                pending
);
  import bfsk_pkg::*;

  // Shadow state
  logic [HASH_W-1:0] run_hash [10];
  bit                probe_map [FILTER_BITS];
  logic [FS_W-1:0]   size_reg;
  logic [NH_W-1:0]   hashes_reg;
  bit                lookups_due [$];

  initial fails = 0;

  always @(posedge clk) begin
    logic [HASH_W-1:0] b, h, sr, modulus, slot;
    int                n_probe;
    bit                hit, want;
    if (rst) begin
      size_reg   = FS_RESET;
      hashes_reg = NH_RESET;
      foreach (run_hash[i]) run_hash[i] = '0;
      foreach (probe_map[i]) probe_map[i] = 1'b0;
      lookups_due.delete();
    end else begin
      // result beat
      if (done) begin
        if (lookups_due.size() == 0) begin
          $error("found: result beat with no lookup outstanding, actual %0b", found);
          fails++;
        end else begin
          want = lookups_due.pop_front();
          if (found !== want) begin
            $error("found: expected %0b, actual %0b", want, found);
            fails++;
          end
        end
      end

      // register write; unknown indexes fall through
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_SIZE: size_reg = cfg_data[FS_W-1:0];
          REG_NUM_HASHES:  hashes_reg = cfg_data[NH_W-1:0];
          default: ;
        endcase
      end

      // key byte beat: roll all ten hashes on the sign-extended byte
      if (start && !busy) begin
        b = {{(HASH_W-KEY_W){key_byte[KEY_W-1]}}, key_byte};
        for (int i = 0; i < 10; i++) begin
          h  = run_hash[i];
          sr = $signed(h) >>> HASH_SHIFT;
          case (i)
            0: h = h + b + HASH_SALT;
            1: h = h + b * 32'd31;
            2: h = h + (b + HASH_SALT) * HASH_MUL;
            3: h = sr + b;
            4: h = (h << HASH_SHIFT) + b;
            5: h = (h << HASH_SHIFT) + sr + b;
            6: h = h + b * HASH_MUL + HASH_SALT;
            7: h = ((h << HASH_SHIFT) + sr) * HASH_MUL + b;
            8: h = sr * HASH_MUL + b;
            default: h = (h << HASH_SHIFT) * HASH_MUL + b;
          endcase
          run_hash[i] = h;
        end

        // key end: clamp modulus and hash count, then probe or set
        if (key_end) begin
          if (size_reg == 0)
            modulus = 1;
          else if (size_reg > FILTER_BITS)
            modulus = FILTER_BITS;
          else
            modulus = size_reg;
          if (hashes_reg == 0)
            n_probe = 1;
          else if (hashes_reg > MAX_HASHES)
            n_probe = MAX_HASHES;
          else
            n_probe = hashes_reg;
          hit = 1'b1;
          for (int i = 0; i < n_probe; i++) begin
            slot = run_hash[i] % modulus;
            if (req_type)
              hit = hit & probe_map[slot];
            else
              probe_map[slot] = 1'b1;
          end
          foreach (run_hash[i]) run_hash[i] = '0;
          if (req_type)
            lookups_due.push_back(hit);
        end
      end
    end
    pending <= lookups_due.size();
  end

endmodule

### sim/bloom_filter_string_keys_tb.sv
`timescale 1ns / 100ps

module bloom_filter_string_keys_tb;
  import bfsk_pkg::*;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int MAX_KEY_LEN     = 8;
  localparam int BEATS_PER_PHASE = 120;
  localparam int POOL_DEPTH      = 48;
  // covers the longest key end
  localparam int SETTLE_CYCLES   = 400;
  localparam int STALL_LIMIT     = 20000;
  localparam int N_SETTINGS      = 8;

  typedef struct packed {
    logic [3:0]                          len;
    logic [MAX_KEY_LEN-1:0][KEY_W-1:0]   text;
  } key_rec_t;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    start     = 1'b0;
  logic                    req_type  = 1'b0;
  logic signed [KEY_W-1:0] key_byte  = '0;
  logic                    key_end   = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data  = '0;
  logic                    busy, done, found, cfg_ready;
  int                      fails, pending;

  int       burst_left  = 0;
  int       quiet_count = 0;
  int       beats_sent  = 0;
  key_rec_t stored_keys [$];

  // Settings swept after the reset phase: size and hash count, extremes included
  int unsigned size_sweep [N_SETTINGS] = '{4096, 1, 0, 8191, 4097, 37, 2048, 0};
  int unsigned hash_sweep [N_SETTINGS] = '{10, 1, 0, 15, 11, 3, 6, 0};

  bloom_filter_string_keys DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .key_byte  (key_byte),
    .key_end   (key_end),
    .done      (done),
    .found     (found),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bloom_filter_string_keys_chk u_found_chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .key_byte  (key_byte),
    .key_end   (key_end),
    .done      (done),
    .found     (found),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done)
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("FAIL bloom_filter_string_keys");
      $finish;
    end
  end

  // One key byte beat, then the burst bookkeeping; a burst ends in a gap
  task automatic send_beat(input logic rt, input logic [KEY_W-1:0] kb, input logic ke);
    int gap;
    start    <= 1'b1;
    req_type <= rt;
    key_byte <= kb;
    key_end  <= ke;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Whole key; type only matters on the last byte, so the rest is noise
  task automatic send_key(input key_rec_t k, input logic lookup);
    for (int i = 0; i < k.len; i++)
      send_beat((i == k.len - 1) ? lookup : 1'($urandom_range(0, 1)), k.text[i],
                i == k.len - 1);
  endtask

  function automatic key_rec_t make_key(input int n, input logic [31:0] bytes);
    key_rec_t k;
    k.len  = 4'(n);
    k.text = '0;
    for (int i = 0; i < n; i++) k.text[i] = bytes[8*i +: 8];
    return k;
  endfunction

  // Mostly short keys, some up to the longest
  function automatic key_rec_t random_key();
    key_rec_t k;
    k.len  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, MAX_KEY_LEN))
                                          : 4'($urandom_range(1, 4));
    k.text = {$urandom, $urandom};
    return k;
  endfunction

  // Inserts feed a pool; lookups replay pooled keys or try fresh ones
  task automatic random_phase(input int n_beats);
    int       first;
    int       pick;
    key_rec_t k;
    first = beats_sent;
    while (beats_sent - first < n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 || stored_keys.size() == 0) begin
        k = random_key();
        send_key(k, REQ_INSERT);
        stored_keys.push_back(k);
        if (stored_keys.size() > POOL_DEPTH) void'(stored_keys.pop_front());
      end else if (pick < 75) begin
        send_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)], REQ_LOOKUP);
      end else begin
        send_key(random_key(), REQ_LOOKUP);
      end
    end
  endtask

  // Drop start, wait out the outstanding lookups and any insert still probing
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Junk in the upper data bits and on the spare indexes must be ignored
  task automatic configure(input int unsigned fs, input int unsigned nh);
    logic [CFG_W-1:0] val;
    write_reg(REG_FILTER_SIZE, fs[CFG_W-1:0]);
    val = CFG_W'($urandom);
    val[NH_W-1:0] = nh[NH_W-1:0];
    write_reg(REG_NUM_HASHES, val);
    write_reg(REG_SPARE_A, CFG_W'($urandom));
    write_reg(REG_SPARE_B, CFG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    key_rec_t k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // bit store clearing sweep
    repeat (2) @(posedge clk);
    do @(posedge clk); while (busy);

    // Directed keys at reset settings: byte extremes, zero byte, hit and miss
    k = make_key(1, 32'h0000_0080);
    send_key(k, REQ_INSERT);
    send_key(k, REQ_LOOKUP);
    send_key(make_key(1, 32'h0000_007F), REQ_LOOKUP);
    k = make_key(4, 32'h01FF_7F00);
    send_key(k, REQ_INSERT);
    send_key(k, REQ_LOOKUP);
    send_key(make_key(1, 32'h0000_0000), REQ_LOOKUP);
    k = make_key(3, 32'h0000_807F);
    send_key(k, REQ_INSERT);
    send_key(k, REQ_LOOKUP);
    random_phase(BEATS_PER_PHASE);

    // Sweep the register settings; the last pair is random
    size_sweep[N_SETTINGS-1] = $urandom_range(2, 4096);
    hash_sweep[N_SETTINGS-1] = $urandom_range(2, 9);
    for (int s = 0; s < N_SETTINGS; s++) begin
      quiesce();
      configure(size_sweep[s], hash_sweep[s]);
      random_phase(BEATS_PER_PHASE);
    end

    quiesce();
    if (fails == 0 && pending == 0)
      $display("PASS bloom_filter_string_keys");
    else
      $display("FAIL bloom_filter_string_keys");
    $finish;
  end

endmodule
